@@ design/pbrld_pkg.sv @@
// Shared types, constants and control records for the PackBits run-length decoder.
package pbrld_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned HDR_W    = 10;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned RUN_W    = 8;

    localparam logic [HDR_W-1:0]   HEADER_BYTES_RESET = 10'd512;
    localparam logic [BYTE_W-1:0]  LITERAL_MAX        = 8'd127;
    localparam logic [BYTE_W-1:0]  CTRL_NOP           = 8'd128;
    localparam logic [8:0]         REPEAT_BASE        = 9'd257;
    localparam logic [COUNT_W-1:0] WORD_BYTES         = 3'd4;

    typedef enum logic [1:0] {
        PH_SKIP = 2'd0,
        PH_CTRL = 2'd1,
        PH_LIT  = 2'd2,
        PH_REP  = 2'd3
    } phase_t;

    typedef enum logic {
        ST_ACCEPT = 1'b0,
        ST_REPEAT = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic rep_start;
        logic rep_last;
    } dp_status_t;

endpackage

@@ design/pbrld_in_if.sv @@
// Compressed byte channel: valid, ready and one file byte with its start flag.
interface pbrld_in_if;
    logic                         valid;
    logic                         ready;
    logic [pbrld_pkg::BYTE_W-1:0] in_byte;
    logic                         start_of_file;

    modport source (output valid, output in_byte, output start_of_file, input ready);
    modport sink   (input valid, input in_byte, input start_of_file, output ready);
endinterface

@@ design/pbrld_out_if.sv @@
// Decoded word channel: valid, ready and up to four packed bytes with count and flag.
interface pbrld_out_if;
    logic                          valid;
    logic                          ready;
    logic [pbrld_pkg::WORD_W-1:0]  out_data;
    logic [pbrld_pkg::COUNT_W-1:0] byte_count;
    logic                          last_of_run;

    modport source (output valid, output out_data, output byte_count, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_data, input byte_count, input last_of_run,
                    output ready);
endinterface

@@ design/pbrld_datapath.sv @@
// Datapath: header register, decode state, repeat counter and output register.
module pbrld_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pbrld_pkg::HDR_W-1:0]     cfg_data,
    input  logic [pbrld_pkg::BYTE_W-1:0]    in_byte,
    input  logic                            start_of_file,
    input  logic                            out_ready,
    input  pbrld_pkg::dp_cmd_t              cmd,
    output pbrld_pkg::dp_status_t           status,
    output logic                            out_valid,
    output logic [pbrld_pkg::WORD_W-1:0]    out_data,
    output logic [pbrld_pkg::COUNT_W-1:0]   out_count,
    output logic                            out_last
);

    logic [pbrld_pkg::HDR_W-1:0]   header_reg;
    logic [pbrld_pkg::HDR_W-1:0]   skip_reg, skip_next;
    pbrld_pkg::phase_t             phase_reg, phase_next;
    logic [pbrld_pkg::RUN_W-1:0]   remaining_reg, remaining_next;
    logic [pbrld_pkg::BYTE_W-1:0]  rep_byte_reg;
    logic [pbrld_pkg::RUN_W-1:0]   rep_cnt_reg, rep_cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic [pbrld_pkg::WORD_W-1:0]  out_data_reg, out_data_next;
    logic [pbrld_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic                          out_last_reg, out_last_next;

    logic [pbrld_pkg::HDR_W-1:0]   eff_skip;
    pbrld_pkg::phase_t             eff_phase;
    logic [pbrld_pkg::RUN_W-1:0]   eff_remaining;
    logic [pbrld_pkg::RUN_W-1:0]   lit_left;
    logic [pbrld_pkg::COUNT_W-1:0] rep_k;
    logic [pbrld_pkg::WORD_W-1:0]  rep_word;
    logic                          out_free;
    logic                          rep_start;
    logic                          load_literal;

    assign out_free = !out_valid_reg || out_ready;

    // Decode of the offered byte; state only moves when the controller accepts it.
    always_comb
    begin
        eff_skip       = start_of_file ? '0 : skip_reg;
        eff_phase      = start_of_file ? pbrld_pkg::PH_SKIP : phase_reg;
        eff_remaining  = start_of_file ? '0 : remaining_reg;
        skip_next      = eff_skip;
        phase_next     = eff_phase;
        remaining_next = eff_remaining;
        rep_start      = 1'b0;
        load_literal   = 1'b0;
        lit_left       = eff_remaining - 8'd1;
        if (eff_phase == pbrld_pkg::PH_SKIP && eff_skip < header_reg)
        begin
            skip_next = eff_skip + 10'd1;
        end
        else
        begin
            if (eff_phase == pbrld_pkg::PH_SKIP)
            begin
                phase_next = pbrld_pkg::PH_CTRL;
            end
            case (phase_next)
                pbrld_pkg::PH_CTRL:
                begin
                    if (in_byte <= pbrld_pkg::LITERAL_MAX)
                    begin
                        remaining_next = in_byte + 8'd1;
                        phase_next     = pbrld_pkg::PH_LIT;
                    end
                    else if (in_byte != pbrld_pkg::CTRL_NOP)
                    begin
                        remaining_next = pbrld_pkg::RUN_W'(pbrld_pkg::REPEAT_BASE
                                                           - {1'b0, in_byte});
                        phase_next     = pbrld_pkg::PH_REP;
                    end
                end
                pbrld_pkg::PH_LIT:
                begin
                    load_literal   = 1'b1;
                    remaining_next = lit_left;
                    if (lit_left == '0)
                    begin
                        phase_next = pbrld_pkg::PH_CTRL;
                    end
                end
                pbrld_pkg::PH_REP:
                begin
                    rep_start      = 1'b1;
                    remaining_next = '0;
                    phase_next     = pbrld_pkg::PH_CTRL;
                end
                default:
                begin
                    phase_next = pbrld_pkg::PH_CTRL;
                end
            endcase
        end
    end

    // One repeat word: up to four copies of the held byte.
    always_comb
    begin
        rep_k = (rep_cnt_reg > 8'd4) ? pbrld_pkg::WORD_BYTES
                                     : pbrld_pkg::COUNT_W'(rep_cnt_reg);
        for (int i = 0; i < 4; i++)
        begin
            rep_word[i*8 +: 8] = (3'(i) < rep_k) ? rep_byte_reg : 8'd0;
        end
    end

    always_comb
    begin
        rep_cnt_next   = rep_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        if (cmd.accept && rep_start)
        begin
            rep_cnt_next = eff_remaining;
        end
        if (cmd.accept && load_literal)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {24'd0, in_byte};
            out_count_next = 3'd1;
            out_last_next  = 1'b1;
        end
        else if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = rep_word;
            out_count_next = rep_k;
            out_last_next  = (rep_cnt_reg <= 8'd4);
            rep_cnt_next   = rep_cnt_reg - pbrld_pkg::RUN_W'(rep_k);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg    <= pbrld_pkg::HEADER_BYTES_RESET;
            skip_reg      <= '0;
            phase_reg     <= pbrld_pkg::PH_SKIP;
            remaining_reg <= '0;
            rep_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                header_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                skip_reg      <= skip_next;
                phase_reg     <= phase_next;
                remaining_reg <= remaining_next;
            end
            rep_cnt_reg   <= rep_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && rep_start)
        begin
            rep_byte_reg <= in_byte;
        end
        out_data_reg  <= out_data_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    assign status.out_free  = out_free;
    assign status.rep_start = rep_start;
    assign status.rep_last  = (rep_cnt_reg <= 8'd4);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;

endmodule

@@ design/pbrld_controller.sv @@
// Controller: takes bytes in, then sequences the words of a repeat run.
module pbrld_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  pbrld_pkg::dp_status_t status,
    output logic                  in_ready,
    output pbrld_pkg::dp_cmd_t    cmd
);

    pbrld_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbrld_pkg::ST_ACCEPT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.emit   = 1'b0;
        case (state_reg)
            pbrld_pkg::ST_ACCEPT:
            begin
                // A literal lands in the output register, so it must be free.
                in_ready   = status.out_free;
                cmd.accept = in_valid && status.out_free;
                if (cmd.accept && status.rep_start)
                begin
                    state_next = pbrld_pkg::ST_REPEAT;
                end
            end
            pbrld_pkg::ST_REPEAT:
            begin
                cmd.emit = status.out_free;
                if (status.out_free && status.rep_last)
                begin
                    state_next = pbrld_pkg::ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = pbrld_pkg::ST_ACCEPT;
            end
        endcase
    end

endmodule

@@ design/packbits_run_length_decoder.sv @@
// Latency: a literal byte's result is valid in the cycle after its transfer; a repeat run's
// first word is formed from the registered byte and count; then one word per cycle while taken.
// Throughput: header, control and literal bytes are taken one per cycle while the output register
// is free; a repeat byte of n copies holds the input until its ceil(n/4) words are sent, as the single
// output register emits one word per cycle while taken, and a result that waits holds off every byte.
// Reset: header_bytes is 512, a header skip is pending and no result is held.
module packbits_run_length_decoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [pbrld_pkg::HDR_W-1:0]  cfg_data,
    pbrld_in_if.sink                     compressed,
    pbrld_out_if.source                  decoded
);

    // Commands from the controller and status back from the datapath.
    pbrld_pkg::dp_cmd_t    cmd;
    pbrld_pkg::dp_status_t status;
    logic                  in_ready;

    // The controller decides when a byte transfer happens and when a repeat word is
    // produced. It sees nothing of the payload beyond the datapath's status.
    pbrld_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (compressed.valid),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    assign compressed.ready = in_ready;

    // The datapath holds the header length, the skip counter, the decode phase,
    // the pending run and the output register. A byte can be taken in the same
    // cycle as the held result leaves, but not while that result still waits.
    pbrld_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_byte       (compressed.in_byte),
        .start_of_file (compressed.start_of_file),
        .out_ready     (decoded.ready),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (decoded.valid),
        .out_data      (decoded.out_data),
        .out_count     (decoded.byte_count),
        .out_last      (decoded.last_of_run)
    );

endmodule
